[src/bcfr_pkg.sv]
// shared types, constants and curve tables for the battery charge frame rewriter
package bcfr_pkg;

    localparam int CHARGE_WIDTH_DEF     = 40;
    localparam int REST_COUNT_WIDTH_DEF = 17;

    localparam logic [10:0] ID_DATA   = 11'h373;
    localparam logic [10:0] ID_CHARGE = 11'h374;
    localparam logic [7:0]  FORCE_HIGH_CODE = 8'd210;
    localparam logic [7:0]  REPORT_BIAS     = 8'd10;
    localparam logic [7:0]  REPORT_FULL     = 8'd200;
    localparam logic [7:0]  MIN_CELL_RESET  = 8'd66;
    localparam int          UNITS_PER_AH    = 36000000;
    localparam int          UNITS_PER_HALF  = 180000;
    localparam int          SOC_FULL        = 11372700;
    localparam int          SOC_PER_HALF    = 50000;

    // register indexes
    localparam logic [2:0] REG_CAPACITY  = 3'd0;
    localparam logic [2:0] REG_ZERO      = 3'd1;
    localparam logic [2:0] REG_REST_BAND = 3'd2;
    localparam logic [2:0] REG_REST_NEED = 3'd3;
    localparam logic [2:0] REG_STARTUP   = 3'd4;

    localparam logic [6:0]  CAPACITY_RESET  = 7'd90;
    localparam logic [15:0] ZERO_RESET      = 16'd32700;
    localparam logic [15:0] REST_BAND_RESET = 16'd200;
    localparam logic [16:0] REST_NEED_RESET = 17'd60000;
    localparam logic [4:0]  STARTUP_RESET   = 5'd20;

    typedef struct packed {
        logic        source_bus;
        logic [10:0] frame_id;
        logic [63:0] payload_bytes;
        logic        max_cell_force;
    } t_in_word;

    typedef struct packed {
        logic        dest_bus;
        logic [10:0] out_frame_id;
        logic [63:0] out_payload_bytes;
    } t_out_word;

    typedef struct packed {
        logic [6:0]  capacity_ah;
        logic [15:0] current_zero_code;
        logic [15:0] rest_band_code;
        logic [16:0] rest_frames_needed;
        logic [4:0]  startup_frames;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SOC,        // register curve soc
        ST_MUL,        // soc * capacity
        ST_RECIP,      // divide by 5 through reciprocal
        ST_SEED,       // seed counters (data) / rest seed (charge)
        ST_ADD,        // add current
        ST_CLAMP,      // charge frame clamp
        ST_DIV1,
        ST_DIV2,
        ST_DONE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic soc;
        logic mul;
        logic recip;
        logic seed;
        logic add;
        logic clamp;
        logic div_start;
        logic div_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic is_data;
        logic is_charge;
        logic div_done;
    } t_status;

    // curve: soc in 1e-5 percent for minimum cell byte v
    function automatic logic [23:0] curve_soc(input logic [7:0] v);
        logic [17:0] slope;
        logic [25:0] offs;
        logic [27:0] prod;
        logic [9:0]  c;
        slope = 18'd0;
        offs  = 26'd0;
        c     = {2'b00, v} + 10'd210;
        if (v < 8'd90)       begin slope = 18'd4082;   offs = 26'd1122550;  end
        else if (v < 8'd137) begin slope = 18'd33497;  offs = 26'd9947100;  end
        else if (v < 8'd150) begin slope = 18'd132143; offs = 26'd44157300; end
        else if (v < 8'd162) begin slope = 18'd183199; offs = 26'd62568400; end
        else if (v < 8'd171) begin slope = 18'd89213;  offs = 26'd27596200; end
        else if (v < 8'd182) begin slope = 18'd131098; offs = 26'd43550000; end
        else if (v < 8'd190) begin slope = 18'd100031; offs = 26'd31368600; end
        else                 begin slope = 18'd135913; offs = 26'd45710600; end
        prod = 28'(slope) * 28'(c);
        if (v < 8'd65) curve_soc = 24'd0;
        else if (v >= 8'd210) curve_soc = 24'(SOC_FULL);
        else if (prod <= {2'b00, offs}) curve_soc = 24'd0;
        else curve_soc = 24'(prod - {2'b00, offs});
    endfunction

endpackage

[src/battery_charge_frame_rewriter.sv]
// top level of the battery charge frame rewriter
//   channel | direction | handshake          | payload
//   in      | input     | i_in_valid/o_in_stall  | t_in_word
//   out     | output    | o_out_valid/i_out_stall| t_out_word
//   cfg     | input     | apb psel/penable   | 32-bit registers
// one word at a time: other frames go straight to the result, data frames also pass
// the scaling and add states, and charge frames the scaling, the clamp and a
// bit-serial divide by capacity*180000; no new word is taken until the result leaves.
// reset restores the register defaults and the counter state.
// the result word holds while i_out_stall is high; no new word is taken meanwhile.
module battery_charge_frame_rewriter #(
    parameter int CHARGE_WIDTH     = bcfr_pkg::CHARGE_WIDTH_DEF,
    parameter int REST_COUNT_WIDTH = bcfr_pkg::REST_COUNT_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bcfr_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bcfr_pkg::t_out_word o_out_word,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    bcfr_pkg::t_cfg    r_cfg;
    bcfr_pkg::t_cmd    cmd;
    bcfr_pkg::t_status status;
    logic [2:0]        reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.capacity_ah        <= bcfr_pkg::CAPACITY_RESET;
            r_cfg.current_zero_code  <= bcfr_pkg::ZERO_RESET;
            r_cfg.rest_band_code     <= bcfr_pkg::REST_BAND_RESET;
            r_cfg.rest_frames_needed <= bcfr_pkg::REST_NEED_RESET;
            r_cfg.startup_frames     <= bcfr_pkg::STARTUP_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                bcfr_pkg::REG_CAPACITY:  r_cfg.capacity_ah        <= pwdata[6:0];
                bcfr_pkg::REG_ZERO:      r_cfg.current_zero_code  <= pwdata[15:0];
                bcfr_pkg::REG_REST_BAND: r_cfg.rest_band_code     <= pwdata[15:0];
                bcfr_pkg::REG_REST_NEED: r_cfg.rest_frames_needed <= pwdata[16:0];
                bcfr_pkg::REG_STARTUP:   r_cfg.startup_frames     <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            bcfr_pkg::REG_CAPACITY:  prdata = {25'd0, r_cfg.capacity_ah};
            bcfr_pkg::REG_ZERO:      prdata = {16'd0, r_cfg.current_zero_code};
            bcfr_pkg::REG_REST_BAND: prdata = {16'd0, r_cfg.rest_band_code};
            bcfr_pkg::REG_REST_NEED: prdata = {15'd0, r_cfg.rest_frames_needed};
            bcfr_pkg::REG_STARTUP:   prdata = {27'd0, r_cfg.startup_frames};
            default:                 prdata = 32'd0;
        endcase
    end

    bcfr_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_status(status), .o_cmd(cmd)
    );

    bcfr_datapath #(
        .CHARGE_WIDTH(CHARGE_WIDTH), .REST_COUNT_WIDTH(REST_COUNT_WIDTH)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_word(i_in_word), .i_cfg(r_cfg),
        .i_cmd(cmd), .o_status(status), .o_out_word(o_out_word)
    );

endmodule

[src/bcfr_ctrl.sv]
// controller state machine for the battery charge frame rewriter
module bcfr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  bcfr_pkg::t_status i_status,
    output bcfr_pkg::t_cmd    o_cmd
);

    bcfr_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= bcfr_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bcfr_pkg::ST_IDLE:  if (i_in_valid) n_state = bcfr_pkg::ST_SOC;
            bcfr_pkg::ST_SOC: begin
                if (i_status.is_data || i_status.is_charge) n_state = bcfr_pkg::ST_MUL;
                else n_state = bcfr_pkg::ST_DONE;
            end
            bcfr_pkg::ST_MUL:   n_state = bcfr_pkg::ST_RECIP;
            bcfr_pkg::ST_RECIP: n_state = bcfr_pkg::ST_SEED;
            bcfr_pkg::ST_SEED: begin
                if (i_status.is_data) n_state = bcfr_pkg::ST_ADD;
                else n_state = bcfr_pkg::ST_CLAMP;
            end
            bcfr_pkg::ST_ADD:   n_state = bcfr_pkg::ST_DONE;
            bcfr_pkg::ST_CLAMP: n_state = bcfr_pkg::ST_DIV1;
            bcfr_pkg::ST_DIV1:  n_state = bcfr_pkg::ST_DIV2;
            bcfr_pkg::ST_DIV2:  if (i_status.div_done) n_state = bcfr_pkg::ST_DONE;
            bcfr_pkg::ST_DONE:  n_state = bcfr_pkg::ST_OUT;
            bcfr_pkg::ST_OUT:   if (!i_out_stall) n_state = bcfr_pkg::ST_IDLE;
            default:            n_state = bcfr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            bcfr_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            bcfr_pkg::ST_SOC:   o_cmd.soc   = 1'b1;
            bcfr_pkg::ST_MUL:   o_cmd.mul   = 1'b1;
            bcfr_pkg::ST_RECIP: o_cmd.recip = 1'b1;
            bcfr_pkg::ST_SEED:  o_cmd.seed  = 1'b1;
            bcfr_pkg::ST_ADD:   o_cmd.add   = 1'b1;
            bcfr_pkg::ST_CLAMP: o_cmd.clamp = 1'b1;
            bcfr_pkg::ST_DIV1:  o_cmd.div_start = 1'b1;
            bcfr_pkg::ST_DIV2:  o_cmd.div_step  = 1'b1;
            bcfr_pkg::ST_DONE:  o_cmd.finish    = 1'b1;
            bcfr_pkg::ST_OUT:   o_out_valid     = 1'b1;
            default: ;
        endcase
    end

endmodule

[src/bcfr_datapath.sv]
// counters, curve, scaling and frame rewrite datapath
module bcfr_datapath #(
    parameter int CHARGE_WIDTH     = bcfr_pkg::CHARGE_WIDTH_DEF,
    parameter int REST_COUNT_WIDTH = bcfr_pkg::REST_COUNT_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bcfr_pkg::t_in_word  i_in_word,
    input  bcfr_pkg::t_cfg      i_cfg,
    input  bcfr_pkg::t_cmd      i_cmd,
    output bcfr_pkg::t_status   o_status,
    output bcfr_pkg::t_out_word o_out_word
);

    localparam int QW = 28;   // quotient register, covers counter / 180000
    localparam int DW = CHARGE_WIDTH + 1;
    localparam logic signed [CHARGE_WIDTH-1:0] CMAX =
        {1'b0, {(CHARGE_WIDTH-1){1'b1}}};
    localparam logic signed [CHARGE_WIDTH-1:0] CMIN =
        {1'b1, {(CHARGE_WIDTH-1){1'b0}}};
    localparam logic [REST_COUNT_WIDTH-1:0] REST_MAX = '1;
    localparam logic [31:0] RECIP5     = 32'hCCCC_CCCD;   // ceil(2^34 / 5)
    localparam logic [24:0] RECIP_HALF = 25'd21990233;    // ceil(2^40 / 50000)

    bcfr_pkg::t_in_word r_in;
    logic signed [CHARGE_WIDTH-1:0] r_cnt, r_cor;
    logic [7:0]                    r_min;
    logic [4:0]                    r_sc;
    logic                          r_seeded;
    logic [REST_COUNT_WIDTH-1:0]   r_rest;
    logic [23:0]                   r_soc;
    logic [30:0]                   r_prod;      // soc*cap, fits 31 bits
    logic [28:0]                   r_q5;        // soc*cap / 5
    logic [63:0]                   r_pay;
    logic                          r_rest_seed;
    logic                          r_need_seed;
    // two restoring dividers run side by side on one denominator, one quotient bit a cycle
    logic [CHARGE_WIDTH-2:0]       r_num1, r_num2;
    logic [DW-1:0]                 r_rem1, r_rem2;
    logic [QW-1:0]                 r_q1, r_q2;
    logic                          r_neg1, r_neg2, r_full1, r_full2;
    logic [$clog2(CHARGE_WIDTH)-1:0] r_bit;
    logic [DW-1:0]                 r_den;

    logic [6:0]  cap;
    logic signed [CHARGE_WIDTH-1:0] full_c, seed_c;
    logic signed [CHARGE_WIDTH+1:0] sum_c, sum_r;
    logic signed [16:0] d;
    logic [16:0] mag;
    logic [7:0]  vb;
    logic [DW-1:0] t1, t2;
    logic [62:0] recip_prod;
    logic [30:0] five_q;
    logic [2:0]  rem5;
    logic [3:0]  round_add;
    logic [33:0] seed_val;
    logic [48:0] half_prod;
    logic [8:0]  soc_half;
    logic [7:0]  rep1, rep2;

    assign cap    = (i_cfg.capacity_ah == 7'd0) ? 7'd1 : i_cfg.capacity_ah;
    assign full_c = CHARGE_WIDTH'(33'(cap) * 33'(bcfr_pkg::UNITS_PER_AH));
    assign vb     = r_in.payload_bytes[15:8];
    assign d      = $signed({1'b0, r_in.payload_bytes[23:16], r_in.payload_bytes[31:24]})
                  - $signed({1'b0, i_cfg.current_zero_code});
    assign mag    = d[16] ? 17'(-d) : 17'(d);

    // (18y + 2) / 5 with y = 5q + b is 18q + (18b + 2) / 5
    assign recip_prod = 63'(r_prod) * 63'(RECIP5);
    assign five_q     = {r_q5, 2'b00} + 31'(r_q5);
    assign rem5       = 3'(r_prod - five_q);

    always_comb begin
        case (rem5)
            3'd1:    round_add = 4'd4;
            3'd2:    round_add = 4'd7;
            3'd3:    round_add = 4'd11;
            3'd4:    round_add = 4'd14;
            default: round_add = 4'd0;
        endcase
    end

    assign seed_val = 34'({r_q5, 4'b0000}) + 34'({r_q5, 1'b0}) + 34'(round_add);
    // seed fits in CHARGE_WIDTH for all capacities since max is under 2^36
    assign seed_c = CHARGE_WIDTH'(seed_val);
    assign sum_c  = (CHARGE_WIDTH+2)'(r_cnt) + (CHARGE_WIDTH+2)'(d);
    assign sum_r  = (CHARGE_WIDTH+2)'(r_cor) + (CHARGE_WIDTH+2)'(d);
    assign t1 = {r_rem1[DW-2:0], r_num1[CHARGE_WIDTH-2]};
    assign t2 = {r_rem2[DW-2:0], r_num2[CHARGE_WIDTH-2]};
    // soc / 50000 by reciprocal, exact for any 24-bit soc
    assign half_prod = 49'(r_soc) * 49'(RECIP_HALF);
    assign soc_half  = half_prod[48:40];

    function automatic logic signed [CHARGE_WIDTH-1:0] sat(
        input logic signed [CHARGE_WIDTH+1:0] v);
        if (v > (CHARGE_WIDTH+2)'(CMAX)) sat = CMAX;
        else if (v < (CHARGE_WIDTH+2)'(CMIN)) sat = CMIN;
        else sat = v[CHARGE_WIDTH-1:0];
    endfunction

    always_comb begin
        if (r_full1)     rep1 = bcfr_pkg::REPORT_FULL;
        else if (r_neg1) rep1 = 8'd0;
        else             rep1 = r_q1[7:0];
        if (r_rest_seed) rep2 = (soc_half > 9'd200) ? bcfr_pkg::REPORT_FULL : soc_half[7:0];
        else if (r_full2) rep2 = bcfr_pkg::REPORT_FULL;
        else if (r_neg2)  rep2 = 8'd0;
        else              rep2 = r_q2[7:0];
    end

    assign o_status.is_data   = (r_in.frame_id == bcfr_pkg::ID_DATA);
    assign o_status.is_charge = (r_in.frame_id == bcfr_pkg::ID_CHARGE);
    assign o_status.div_done  = (r_bit == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= CHARGE_WIDTH'(34'(bcfr_pkg::CAPACITY_RESET) * 34'(bcfr_pkg::UNITS_PER_AH));
            r_cor    <= CHARGE_WIDTH'(34'(bcfr_pkg::CAPACITY_RESET) * 34'(bcfr_pkg::UNITS_PER_AH));
            r_min    <= bcfr_pkg::MIN_CELL_RESET;
            r_sc     <= 5'd0;
            r_seeded <= 1'b0;
            r_rest   <= '0;
            r_bit    <= '0;
        end else begin
            if (i_cmd.load) r_in <= i_in_word;
            if (i_cmd.soc) begin
                r_pay <= r_in.payload_bytes;
                if (o_status.is_data && vb > 8'd65 && vb < 8'd210) begin
                    r_min <= vb;
                    r_soc <= bcfr_pkg::curve_soc(vb);
                end else begin
                    r_soc <= bcfr_pkg::curve_soc(r_min);
                end
                r_need_seed <= o_status.is_data && !r_seeded && (r_sc >= i_cfg.startup_frames);
                r_rest_seed <= o_status.is_charge &&
                    (32'(r_rest) > 32'(i_cfg.rest_frames_needed));
                if (o_status.is_data && !r_seeded && r_sc < i_cfg.startup_frames
                    && r_sc != 5'd31)
                    r_sc <= r_sc + 5'd1;
            end
            if (i_cmd.mul) r_prod <= 31'(r_soc) * 31'(cap);
            if (i_cmd.recip) r_q5 <= recip_prod[62:34];
            if (i_cmd.seed) begin
                if (r_need_seed) begin
                    r_cnt    <= seed_c;
                    r_cor    <= seed_c;
                    r_seeded <= 1'b1;
                end
                if (r_rest_seed) r_cor <= seed_c;
            end
            if (i_cmd.add) begin
                r_cnt <= sat(sum_c);
                r_cor <= sat(sum_r);
                if (mag < {1'b0, i_cfg.rest_band_code}) begin
                    if (r_rest != REST_MAX) r_rest <= r_rest + 1'b1;
                end else begin
                    r_rest <= '0;
                end
                if (r_in.max_cell_force) r_pay[7:0] <= bcfr_pkg::FORCE_HIGH_CODE;
            end
            if (i_cmd.clamp) begin
                r_full1 <= r_cnt > full_c;
                r_neg1  <= r_cnt[CHARGE_WIDTH-1];
                r_full2 <= !r_rest_seed && (r_cor > full_c);
                r_neg2  <= r_cor[CHARGE_WIDTH-1];
                if (r_cnt > full_c) r_cnt <= full_c;
                if (!r_rest_seed && r_cor > full_c) r_cor <= full_c;
                r_pay[55:48] <= {cap, 1'b0};
            end
            if (i_cmd.div_start) begin
                r_num1 <= r_cnt[CHARGE_WIDTH-2:0];
                r_num2 <= r_cor[CHARGE_WIDTH-2:0];
                r_rem1 <= '0;
                r_rem2 <= '0;
                r_q1   <= '0;
                r_q2   <= '0;
                r_den  <= DW'(25'(cap) * 25'(bcfr_pkg::UNITS_PER_HALF));
                r_bit  <= ($clog2(CHARGE_WIDTH))'(CHARGE_WIDTH - 1);
            end
            if (i_cmd.div_step && r_bit != '0) begin
                r_bit  <= r_bit - 1'b1;
                r_num1 <= r_num1 << 1;
                r_num2 <= r_num2 << 1;
                if (t1 >= r_den) begin
                    r_rem1 <= t1 - r_den;
                    r_q1   <= {r_q1[QW-2:0], 1'b1};
                end else begin
                    r_rem1 <= t1;
                    r_q1   <= {r_q1[QW-2:0], 1'b0};
                end
                if (t2 >= r_den) begin
                    r_rem2 <= t2 - r_den;
                    r_q2   <= {r_q2[QW-2:0], 1'b1};
                end else begin
                    r_rem2 <= t2;
                    r_q2   <= {r_q2[QW-2:0], 1'b0};
                end
            end
            if (i_cmd.finish && o_status.is_charge) begin
                r_pay[7:0]  <= rep1 + bcfr_pkg::REPORT_BIAS;
                r_pay[15:8] <= rep2 + bcfr_pkg::REPORT_BIAS;
            end
        end
    end

    assign o_out_word.dest_bus          = ~r_in.source_bus;
    assign o_out_word.out_frame_id      = r_in.frame_id;
    assign o_out_word.out_payload_bytes = r_pay;

endmodule

[src/bcfr_checker.sv]
// port-level checks for the battery charge frame rewriter, bound to the top
module bcfr_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input bcfr_pkg::t_in_word  i_in_word,
    input bcfr_pkg::t_out_word o_out_word
);

    // one word in flight: no intake while a result is shown
    a_no_intake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall) else $error("intake while result pending");

    // accepted word never gives a result in the next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> !o_out_valid) else $error("result too early");

    a_bus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> ##2 (o_out_word.dest_bus == !$past(i_in_word.source_bus, 3)))
        else $error("bus not swapped");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled result changed");

endmodule

bind battery_charge_frame_rewriter bcfr_checker u_bcfr_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
    .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
    .i_in_word(i_in_word), .o_out_word(o_out_word)
);

[bench/battery_charge_frame_checker.sv]
// checker for the battery charge frame rewriter: predicts each output word and compares
`timescale 1ns / 1ps
module battery_charge_frame_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  bcfr_pkg::t_in_word  i_in_word,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  bcfr_pkg::t_out_word i_out_word,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam int CW = bcfr_pkg::CHARGE_WIDTH_DEF;
    localparam int RW = bcfr_pkg::REST_COUNT_WIDTH_DEF;
    localparam longint CHG_MAX = (64'sd1 <<< (CW - 1)) - 1;
    localparam longint CHG_MIN = -CHG_MAX - 1;

    bcfr_pkg::t_cfg      cfg;
    longint              counted_q;
    longint              corrected_q;
    logic [7:0]          min_cell_q;
    logic [4:0]          startup_q;
    logic                seeded_q;
    longint              rest_q;
    bcfr_pkg::t_out_word expected_words[$];

    assign o_pending = expected_words.size();

    function automatic longint clip_charge(input longint v);
        if (v > CHG_MAX) return CHG_MAX;
        if (v < CHG_MIN) return CHG_MIN;
        return v;
    endfunction

    function automatic longint cap_used();
        return (cfg.capacity_ah == 0) ? 1 : longint'(cfg.capacity_ah);
    endfunction

    function automatic longint soc_of(input logic [7:0] v);
        longint bound[8] = '{90, 137, 150, 162, 171, 182, 190, 210};
        longint slope[8] = '{4082, 33497, 132143, 183199, 89213, 131098, 100031, 135913};
        longint offs[8]  = '{1122550, 9947100, 44157300, 62568400, 27596200, 43550000,
                             31368600, 45710600};
        longint s;
        if (v < 65) return 0;
        for (int i = 0; i < 8; i++) begin
            if (longint'(v) < bound[i]) begin
                s = slope[i] * (longint'(v) + 210) - offs[i];
                return (s < 0) ? 0 : s;
            end
        end
        return bcfr_pkg::SOC_FULL;
    endfunction

    function automatic longint charge_of_soc(input longint soc);
        return clip_charge((soc * cap_used() * 18 + 2) / 5);
    endfunction

    // half-percent report, clamps the counter at full
    function automatic longint half_pct(inout longint ctr);
        longint full;
        full = cap_used() * bcfr_pkg::UNITS_PER_AH;
        if (ctr > full) begin
            ctr = full;
            return 200;
        end
        if (ctr < 0) return 0;
        return ctr / (cap_used() * bcfr_pkg::UNITS_PER_HALF);
    endfunction

    function automatic bcfr_pkg::t_out_word rewrite_frame(input bcfr_pkg::t_in_word w);
        bcfr_pkg::t_out_word o;
        logic [63:0] p;
        logic [7:0] vb;
        longint d, mag, r1, r2, soc;
        p = w.payload_bytes;
        if (w.frame_id == bcfr_pkg::ID_DATA) begin
            vb = p[15:8];
            if (vb > 65 && vb < 210) min_cell_q = vb;
            if (!seeded_q) begin
                if (startup_q >= cfg.startup_frames) begin
                    counted_q = charge_of_soc(soc_of(min_cell_q));
                    corrected_q = counted_q;
                    seeded_q = 1'b1;
                end else if (startup_q < 31) begin
                    startup_q++;
                end
            end
            d = longint'({p[23:16], p[31:24]}) - longint'(cfg.current_zero_code);
            counted_q = clip_charge(counted_q + d);
            corrected_q = clip_charge(corrected_q + d);
            mag = (d < 0) ? -d : d;
            if (mag < longint'(cfg.rest_band_code)) begin
                if (rest_q < (64'd1 << RW) - 1) rest_q++;
            end else begin
                rest_q = 0;
            end
            if (w.max_cell_force) p[7:0] = bcfr_pkg::FORCE_HIGH_CODE;
        end else if (w.frame_id == bcfr_pkg::ID_CHARGE) begin
            p[55:48] = 8'(cap_used() * 2);
            r1 = half_pct(counted_q);
            if (rest_q > longint'(cfg.rest_frames_needed)) begin
                soc = soc_of(min_cell_q);
                corrected_q = charge_of_soc(soc);
                r2 = soc / bcfr_pkg::SOC_PER_HALF;
                if (r2 > 200) r2 = 200;
            end else begin
                r2 = half_pct(corrected_q);
            end
            p[7:0] = 8'(r1 + 10);
            p[15:8] = 8'(r2 + 10);
        end
        o.dest_bus = ~w.source_bus;
        o.out_frame_id = w.frame_id;
        o.out_payload_bytes = p;
        return o;
    endfunction

    always @(posedge i_clk) begin
        bcfr_pkg::t_out_word e;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            cfg <= '{bcfr_pkg::CAPACITY_RESET, bcfr_pkg::ZERO_RESET,
                     bcfr_pkg::REST_BAND_RESET, bcfr_pkg::REST_NEED_RESET,
                     bcfr_pkg::STARTUP_RESET};
            counted_q <= 90 * longint'(bcfr_pkg::UNITS_PER_AH);
            corrected_q <= 90 * longint'(bcfr_pkg::UNITS_PER_AH);
            min_cell_q <= bcfr_pkg::MIN_CELL_RESET;
            startup_q <= '0;
            seeded_q <= 1'b0;
            rest_q <= 0;
            expected_words.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bcfr_pkg::REG_CAPACITY:  cfg.capacity_ah = i_cfg_data[6:0];
                    bcfr_pkg::REG_ZERO:      cfg.current_zero_code = i_cfg_data[15:0];
                    bcfr_pkg::REG_REST_BAND: cfg.rest_band_code = i_cfg_data[15:0];
                    bcfr_pkg::REG_REST_NEED: cfg.rest_frames_needed = i_cfg_data[16:0];
                    bcfr_pkg::REG_STARTUP:   cfg.startup_frames = i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) expected_words.push_back(rewrite_frame(i_in_word));
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $error("output word with nothing expected: %h", i_out_word);
                    errs++;
                end else begin
                    e = expected_words.pop_front();
                    if (e.dest_bus !== i_out_word.dest_bus) begin
                        $error("dest_bus expected %0d got %0d", e.dest_bus, i_out_word.dest_bus);
                        errs++;
                    end
                    if (e.out_frame_id !== i_out_word.out_frame_id) begin
                        $error("out_frame_id expected %h got %h", e.out_frame_id,
                               i_out_word.out_frame_id);
                        errs++;
                    end
                    if (e.out_payload_bytes !== i_out_word.out_payload_bytes) begin
                        $error("out_payload_bytes expected %h got %h", e.out_payload_bytes,
                               i_out_word.out_payload_bytes);
                        errs++;
                    end
                end
            end
            if (errs != 0) o_fail_count <= o_fail_count + errs;
        end
    end
endmodule

[bench/battery_charge_frame_rewriter_test.sv]
// stimulus and verdict for the battery charge frame rewriter
`timescale 1ns / 1ps
module battery_charge_frame_rewriter_test;

    localparam int CYCLE_LIMIT = 400000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    bcfr_pkg::t_in_word  i_in_word = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    bcfr_pkg::t_out_word o_out_word;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [4:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    int                  fail_count;
    int                  pending;
    int                  cycle_count = 0;
    bit                  calm = 1'b0;
    bit                  hold_long = 1'b0;

    always #2 i_clk = ~i_clk;

    battery_charge_frame_rewriter dut (.*);

    battery_charge_frame_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall), .i_in_word(i_in_word),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_out_word(o_out_word),
        .i_cfg_we(psel && penable && pwrite && pready), .i_cfg_idx(paddr[4:2]),
        .i_cfg_data(pwdata), .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver stall bursts, plus one long hold-off
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_long) begin
                i_out_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_long = 1'b0;
                i_out_stall <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 18);
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic drain_all();
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic send_frame(input bcfr_pkg::t_in_word w);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 18);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic stop_send();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic bcfr_pkg::t_in_word frame_of(input logic [10:0] id,
                                                    input logic [7:0] volt,
                                                    input logic [15:0] cur);
        bcfr_pkg::t_in_word w;
        w.source_bus = 1'($urandom);
        w.frame_id = id;
        w.payload_bytes = {$urandom, $urandom};
        w.payload_bytes[15:8] = volt;
        w.payload_bytes[23:16] = cur[15:8];
        w.payload_bytes[31:24] = cur[7:0];
        w.max_cell_force = 1'($urandom);
        return w;
    endfunction

    function automatic bcfr_pkg::t_in_word random_frame(input int zero, input int band);
        int k;
        logic [10:0] id;
        logic [15:0] cur;
        k = $urandom_range(0, 9);
        id = (k < 6) ? bcfr_pkg::ID_DATA : (k < 9) ? bcfr_pkg::ID_CHARGE : 11'($urandom);
        case ($urandom_range(0, 3))
            0: cur = 16'($urandom);
            1: cur = 16'(zero + $urandom_range(0, 2 * band) - band);
            default: cur = 16'(zero + $urandom_range(0, 4000) - 2000);
        endcase
        return frame_of(id, 8'($urandom_range(50, 230)), cur);
    endfunction

    initial begin
        int caps[4] = '{1, 127, 0, 40};
        int zeros[4] = '{32700, 0, 65535, 30000};
        int bands[4] = '{200, 65535, 0, 1000};
        int needs[4] = '{5, 0, 131071, 20};
        int starts[4] = '{0, 31, 3, 20};
        logic [7:0] volts[10] = '{0, 64, 65, 66, 89, 150, 189, 209, 210, 255};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: curve corners, startup, charge report, pass-through
        foreach (volts[i]) send_frame(frame_of(bcfr_pkg::ID_DATA, volts[i], 16'd32700));
        send_frame(frame_of(bcfr_pkg::ID_DATA, 8'd150, 16'hffff));
        send_frame(frame_of(bcfr_pkg::ID_DATA, 8'd150, 16'h0000));
        for (int i = 0; i < 8; i++) send_frame(frame_of(bcfr_pkg::ID_DATA, 8'd120, 16'd32800));
        send_frame(frame_of(bcfr_pkg::ID_CHARGE, 8'd0, 16'd0));
        send_frame(frame_of(11'h7ff, 8'hff, 16'hffff));
        send_frame(frame_of(11'h000, 8'h00, 16'h0000));
        stop_send();
        drain_all();

        for (int ph = 0; ph < 4; ph++) begin
            reg_write(bcfr_pkg::REG_CAPACITY, caps[ph]);
            reg_write(bcfr_pkg::REG_ZERO, zeros[ph]);
            reg_write(bcfr_pkg::REG_REST_BAND, bands[ph]);
            reg_write(bcfr_pkg::REG_REST_NEED, needs[ph]);
            reg_write(bcfr_pkg::REG_STARTUP, starts[ph]);
            if (ph == 3) calm = 1'b1;
            for (int i = 0; i < 120; i++) begin
                if (ph == 1 && i == 30) hold_long = 1'b1;
                send_frame(random_frame(zeros[ph], bands[ph] > 3000 ? 3000 : bands[ph]));
            end
            stop_send();
            // sender waits out every pending word between phases
            drain_all();
        end

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
